### design/sd_spi_host_sequencer_defines.svh
// ----------------------------------------------------------------------------
// SD SPI host sequencer assertion macros
// Shared forms for the concurrent checks on the sequencer ports.
// ----------------------------------------------------------------------------
`ifndef SD_SPI_HOST_SEQUENCER_DEFINES_SVH
`define SD_SPI_HOST_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SDSH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sd spi host sequencer check failed");

// Next-cycle implication, disabled while reset is asserted
`define SDSH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sd spi host sequencer check failed");

`endif

### design/sdsh_pkg.sv
// ----------------------------------------------------------------------------
// SD SPI host sequencer package
// Payload types, result codes, reset values and result builders.
// ----------------------------------------------------------------------------
package sdsh_pkg;

    // Default data block length in bytes
    localparam int BLOCK_BYTES_DEF = 512;

    // Configuration register indexes and reset values
    localparam logic CFG_R1_RETRY_LIMIT       = 1'b0;
    localparam logic CFG_POWER_ON_DUMMY_COUNT = 1'b1;
    localparam logic [3:0] R1_RETRY_LIMIT_RST       = 4'd8;
    localparam logic [5:0] POWER_ON_DUMMY_COUNT_RST = 6'd10;
    localparam int CFG_DATA_W = 6;

    // Request types
    localparam logic [1:0] REQ_INIT = 2'd0;
    localparam logic [1:0] REQ_READ = 2'd1;
    localparam logic [1:0] REQ_RX   = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NO_CARD     = 3'd1;
    localparam logic [2:0] ST_RESET_FAIL  = 3'd2;
    localparam logic [2:0] ST_VERIFY_FAIL = 3'd3;
    localparam logic [2:0] ST_INIT_FAIL   = 3'd4;
    localparam logic [2:0] ST_READ_REJECT = 3'd5;

    // Bus byte values
    localparam logic [7:0] BYTE_IDLE     = 8'hFF;
    localparam logic [7:0] TOKEN_START   = 8'hFE;
    localparam logic [7:0] R1_IN_IDLE    = 8'h01;
    localparam logic [7:0] CHECK_PATTERN = 8'hAA;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] block_addr;
        logic [7:0]  rx_byte;
        logic        card_present;
    } req_t;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic       select_active;
        logic [2:0] status_code;
        logic       last_out;
    } rsp_t;

    // Results produced by one transaction, first in item0
    typedef struct packed {
        logic [1:0] cnt;
        rsp_t       item0;
        rsp_t       item1;
    } push_t;

    function automatic rsp_t mk_tx(logic [7:0] b, logic sel);
        rsp_t r;
        r.out_kind      = KIND_TX;
        r.out_byte      = b;
        r.select_active = sel;
        r.status_code   = ST_OK;
        r.last_out      = 1'b0;
        return r;
    endfunction

    function automatic rsp_t mk_data(logic [7:0] b);
        rsp_t r;
        r.out_kind      = KIND_DATA;
        r.out_byte      = b;
        r.select_active = 1'b0;
        r.status_code   = ST_OK;
        r.last_out      = 1'b0;
        return r;
    endfunction

    function automatic rsp_t mk_status(logic [2:0] code);
        rsp_t r;
        r.out_kind      = KIND_STATUS;
        r.out_byte      = 8'h00;
        r.select_active = 1'b0;
        r.status_code   = code;
        r.last_out      = 1'b0;
        return r;
    endfunction

endpackage

### design/sd_spi_host_sequencer.sv
// A transaction is held in the input register, then its results in the result buffer.
// Throughput: one transaction per cycle when its results fit; a block data byte gives two results,
// and the result port drains one per cycle, so data bytes wait on the result port.
// The input register frees as soon as its results fit in the two-entry result buffer.
// Reset: sequencer idle, buffers empty, r1_retry_limit 8, power_on_dummy_count 10.
// ----------------------------------------------------------------------------
// SD SPI host sequencer
// Byte-level SD card SPI init and single block read, one card byte per transaction.
// ----------------------------------------------------------------------------
module sd_spi_host_sequencer
#(
    parameter int BLOCK_BYTES = sdsh_pkg::BLOCK_BYTES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  sdsh_pkg::req_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output sdsh_pkg::rsp_t                rsp,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [sdsh_pkg::CFG_DATA_W-1:0] cfg_data
);

    sdsh_pkg::req_t  req_hold_reg;
    logic            req_full_reg;
    logic [3:0]      r1_retry_limit_reg;
    logic [5:0]      power_on_dummy_count_reg;
    sdsh_pkg::push_t push;
    logic [1:0]      space;
    logic            fire;
    logic            accept;

    // Consume the held transaction when all its results fit
    assign fire      = req_full_reg && (push.cnt <= space);
    assign req_stall = req_full_reg && !fire;
    assign accept    = req_valid && !req_stall;

    // Hold the input register and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_full_reg             <= 1'b0;
            r1_retry_limit_reg       <= sdsh_pkg::R1_RETRY_LIMIT_RST;
            power_on_dummy_count_reg <= sdsh_pkg::POWER_ON_DUMMY_COUNT_RST;
        end
        else
        begin
            if (accept)
            begin
                req_full_reg <= 1'b1;
            end
            else if (fire)
            begin
                req_full_reg <= 1'b0;
            end
            if (cfg_we && (cfg_index == sdsh_pkg::CFG_R1_RETRY_LIMIT))
            begin
                r1_retry_limit_reg <= cfg_data[3:0];
            end
            if (cfg_we && (cfg_index == sdsh_pkg::CFG_POWER_ON_DUMMY_COUNT))
            begin
                power_on_dummy_count_reg <= cfg_data[5:0];
            end
        end
    end

    // Capture transaction payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_hold_reg <= req;
        end
    end

    sdsh_core #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_core (
        .clk                  (clk),
        .rst_n                (rst_n),
        .fire                 (fire),
        .item                 (req_hold_reg),
        .r1_retry_limit       (r1_retry_limit_reg),
        .power_on_dummy_count (power_on_dummy_count_reg),
        .push                 (push)
    );

    sdsh_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .push      (push),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .space     (space)
    );

endmodule

### design/sdsh_out_buf.sv
// ----------------------------------------------------------------------------
// SD SPI host sequencer result buffer
// Two-entry result register; takes up to two results per cycle, shows one.
// ----------------------------------------------------------------------------
module sdsh_out_buf
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  sdsh_pkg::push_t push,
    input  logic            rsp_stall,
    output logic            rsp_valid,
    output sdsh_pkg::rsp_t  rsp,
    output logic [1:0]      space
);

    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    sdsh_pkg::rsp_t slot0_reg;
    sdsh_pkg::rsp_t slot0_next;
    sdsh_pkg::rsp_t slot1_reg;
    sdsh_pkg::rsp_t slot1_next;
    logic           pop;
    logic [1:0]     rem;
    logic [1:0]     n_push;

    assign rsp_valid = (count_reg != 2'd0);
    assign rsp       = slot0_reg;
    assign pop       = rsp_valid && !rsp_stall;
    assign space     = 2'(2'd2 - count_reg + {1'b0, pop});
    assign rem       = 2'(count_reg - {1'b0, pop});
    assign n_push    = fire ? push.cnt : 2'd0;

    // Drop the taken head, then append new results behind what remains
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        case (rem)
            2'd0:
            begin
                slot0_next = push.item0;
                slot1_next = push.item1;
            end
            2'd1:
            begin
                slot0_next = pop ? slot1_reg : slot0_reg;
                slot1_next = push.item0;
            end
            default:
            begin
                slot0_next = slot0_reg;
                slot1_next = slot1_reg;
            end
        endcase
        count_next = 2'(rem + n_push);
    end

    // Hold fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Hold result payload
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

### design/sdsh_core.sv
// ----------------------------------------------------------------------------
// SD SPI host sequencer core
// Card init and block read state machine; decides results for one transaction.
// ----------------------------------------------------------------------------
module sdsh_core
#(
    parameter int BLOCK_BYTES = sdsh_pkg::BLOCK_BYTES_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  sdsh_pkg::req_t  item,
    input  logic [3:0]      r1_retry_limit,
    input  logic [5:0]      power_on_dummy_count,
    output sdsh_pkg::push_t push
);

    localparam int IDX_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
    localparam int CNT_W = (IDX_W > 6) ? IDX_W : 6;
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(BLOCK_BYTES - 1);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_PWR,
        PH_GARB,
        PH_READY,
        PH_CMD,
        PH_R1,
        PH_R3,
        PH_TOKEN,
        PH_DATA,
        PH_CRC
    } phase_t;

    typedef enum logic [2:0] {
        CMD_GO,
        CMD_IFC,
        CMD_APP,
        CMD_OPC,
        CMD_OCR,
        CMD_READ
    } cmd_t;

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [CNT_W-1:0] byte_count_reg;
    logic [CNT_W-1:0] byte_count_next;
    logic [3:0]       poll_count_reg;
    logic [3:0]       poll_count_next;
    logic [39:0]      response_bytes_reg;
    logic [39:0]      response_bytes_next;
    logic [31:0]      address_hold_reg;
    logic [31:0]      address_hold_next;
    cmd_t             cur_cmd_reg;
    cmd_t             cur_cmd_next;

    logic             do_start;
    cmd_t             start_sel;
    logic             do_status;
    logic [2:0]       status_val;
    logic [39:0]      resp_shift;
    logic [7:0]       rx;
    sdsh_pkg::push_t  res;

    // Command frame byte at position idx (0 index, 1..4 argument, 5 CRC)
    function automatic logic [7:0] cmd_byte(cmd_t c, logic [2:0] idx, logic [31:0] addr);
        logic [7:0] first;
        logic [7:0] crc;
        logic [31:0] arg;
        case (c)
            CMD_GO:   begin first = 8'h40; crc = 8'h95; arg = 32'h0000_0000; end
            CMD_IFC:  begin first = 8'h48; crc = 8'h87; arg = 32'h0000_01AA; end
            CMD_APP:  begin first = 8'h77; crc = 8'hFF; arg = 32'h0000_0000; end
            CMD_OPC:  begin first = 8'h69; crc = 8'hFF; arg = 32'h4000_00A0; end
            CMD_OCR:  begin first = 8'h7A; crc = 8'hFF; arg = 32'h0000_0000; end
            CMD_READ: begin first = 8'h51; crc = 8'hFF; arg = addr;          end
            default:  begin first = 8'h40; crc = 8'h95; arg = 32'h0000_0000; end
        endcase
        case (idx)
            3'd0:    return first;
            3'd1:    return arg[31:24];
            3'd2:    return arg[23:16];
            3'd3:    return arg[15:8];
            3'd4:    return arg[7:0];
            default: return crc;
        endcase
    endfunction

    assign rx         = item.rx_byte;
    assign resp_shift = {response_bytes_reg[31:0], rx};

    // Decide next state and the results of the held transaction
    always_comb
    begin
        phase_next          = phase_reg;
        byte_count_next     = byte_count_reg;
        poll_count_next     = poll_count_reg;
        response_bytes_next = response_bytes_reg;
        address_hold_next   = address_hold_reg;
        cur_cmd_next        = cur_cmd_reg;
        do_start            = 1'b0;
        start_sel           = cur_cmd_reg;
        do_status           = 1'b0;
        status_val          = sdsh_pkg::ST_OK;
        res                 = '0;

        case (item.req_type)
            sdsh_pkg::REQ_INIT:
            begin
                if (!item.card_present)
                begin
                    do_status  = 1'b1;
                    status_val = sdsh_pkg::ST_NO_CARD;
                end
                else
                begin
                    phase_next          = PH_PWR;
                    byte_count_next     = CNT_W'(1);
                    poll_count_next     = 4'd0;
                    response_bytes_next = 40'd0;
                    res.cnt             = 2'd1;
                    res.item0           = sdsh_pkg::mk_tx(sdsh_pkg::BYTE_IDLE, 1'b0);
                end
            end
            sdsh_pkg::REQ_READ:
            begin
                address_hold_next = item.block_addr;
                cur_cmd_next      = CMD_READ;
                poll_count_next   = 4'd0;
                byte_count_next   = '0;
                phase_next        = PH_READY;
                res.cnt           = 2'd1;
                res.item0         = sdsh_pkg::mk_tx(sdsh_pkg::BYTE_IDLE, 1'b1);
            end
            sdsh_pkg::REQ_RX:
            begin
                case (phase_reg)
                    PH_PWR:
                    begin
                        res.cnt = 2'd1;
                        if (byte_count_reg < CNT_W'(power_on_dummy_count))
                        begin
                            byte_count_next = CNT_W'(byte_count_reg + 1'b1);
                            res.item0 = sdsh_pkg::mk_tx(sdsh_pkg::BYTE_IDLE, 1'b0);
                        end
                        else
                        begin
                            phase_next      = PH_GARB;
                            byte_count_next = CNT_W'(1);
                            res.item0 = sdsh_pkg::mk_tx(sdsh_pkg::BYTE_IDLE, 1'b1);
                        end
                    end
                    PH_GARB:
                    begin
                        if (byte_count_reg < CNT_W'(3))
                        begin
                            byte_count_next = CNT_W'(byte_count_reg + 1'b1);
                            res.cnt   = 2'd1;
                            res.item0 = sdsh_pkg::mk_tx(sdsh_pkg::BYTE_IDLE, 1'b1);
                        end
                        else
                        begin
                            do_start  = 1'b1;
                            start_sel = CMD_GO;
                        end
                    end
                    PH_READY:
                    begin
                        do_start  = 1'b1;
                        start_sel = cur_cmd_reg;
                    end
                    PH_CMD:
                    begin
                        res.cnt   = 2'd1;
                        res.item0 = sdsh_pkg::mk_tx(
                            cmd_byte(cur_cmd_reg, byte_count_reg[2:0], address_hold_reg),
                            1'b1);
                        byte_count_next = CNT_W'(byte_count_reg + 1'b1);
                        if (byte_count_reg >= CNT_W'(5))
                        begin
                            phase_next      = PH_R1;
                            poll_count_next = 4'd0;
                        end
                    end
                    PH_R1:
                    begin
                        if (rx[7] && (poll_count_reg < r1_retry_limit))
                        begin
                            poll_count_next = 4'(poll_count_reg + 1'b1);
                            res.cnt   = 2'd1;
                            res.item0 = sdsh_pkg::mk_tx(sdsh_pkg::BYTE_IDLE, 1'b1);
                        end
                        else
                        begin
                            case (cur_cmd_reg)
                                CMD_GO:
                                begin
                                    if (rx == sdsh_pkg::R1_IN_IDLE)
                                    begin
                                        do_start  = 1'b1;
                                        start_sel = CMD_IFC;
                                    end
                                    else
                                    begin
                                        do_status  = 1'b1;
                                        status_val = sdsh_pkg::ST_RESET_FAIL;
                                    end
                                end
                                CMD_APP:
                                begin
                                    do_start  = 1'b1;
                                    start_sel = CMD_OPC;
                                end
                                CMD_OPC:
                                begin
                                    do_start  = 1'b1;
                                    start_sel = (rx == sdsh_pkg::R1_IN_IDLE) ? CMD_APP : CMD_OCR;
                                end
                                CMD_READ:
                                begin
                                    if (rx != 8'h00)
                                    begin
                                        do_status  = 1'b1;
                                        status_val = sdsh_pkg::ST_READ_REJECT;
                                    end
                                    else
                                    begin
                                        phase_next = PH_TOKEN;
                                        res.cnt    = 2'd1;
                                        res.item0  = sdsh_pkg::mk_tx(sdsh_pkg::BYTE_IDLE, 1'b1);
                                    end
                                end
                                default:
                                begin
                                    // R3/R7 commands: keep R1, collect four more bytes
                                    response_bytes_next = {32'd0, rx};
                                    byte_count_next     = '0;
                                    phase_next          = PH_R3;
                                    res.cnt             = 2'd1;
                                    res.item0 = sdsh_pkg::mk_tx(sdsh_pkg::BYTE_IDLE, 1'b1);
                                end
                            endcase
                        end
                    end
                    PH_R3:
                    begin
                        response_bytes_next = resp_shift;
                        byte_count_next     = CNT_W'(byte_count_reg + 1'b1);
                        if (byte_count_reg < CNT_W'(3))
                        begin
                            res.cnt   = 2'd1;
                            res.item0 = sdsh_pkg::mk_tx(sdsh_pkg::BYTE_IDLE, 1'b1);
                        end
                        else if (cur_cmd_reg == CMD_IFC)
                        begin
                            if (resp_shift[7:0] == sdsh_pkg::CHECK_PATTERN)
                            begin
                                do_start  = 1'b1;
                                start_sel = CMD_APP;
                            end
                            else
                            begin
                                do_status  = 1'b1;
                                status_val = sdsh_pkg::ST_VERIFY_FAIL;
                            end
                        end
                        else
                        begin
                            // R1 clear and OCR card capacity bit set
                            do_status = 1'b1;
                            if ((resp_shift[39:32] == 8'h00) && resp_shift[30])
                            begin
                                status_val = sdsh_pkg::ST_OK;
                            end
                            else
                            begin
                                status_val = sdsh_pkg::ST_INIT_FAIL;
                            end
                        end
                    end
                    PH_TOKEN:
                    begin
                        if (rx == sdsh_pkg::TOKEN_START)
                        begin
                            phase_next      = PH_DATA;
                            byte_count_next = '0;
                        end
                        res.cnt   = 2'd1;
                        res.item0 = sdsh_pkg::mk_tx(sdsh_pkg::BYTE_IDLE, 1'b1);
                    end
                    PH_DATA:
                    begin
                        res.cnt   = 2'd2;
                        res.item0 = sdsh_pkg::mk_data(rx);
                        res.item1 = sdsh_pkg::mk_tx(sdsh_pkg::BYTE_IDLE, 1'b1);
                        if (byte_count_reg >= LAST_IDX)
                        begin
                            phase_next      = PH_CRC;
                            byte_count_next = '0;
                        end
                        else
                        begin
                            byte_count_next = CNT_W'(byte_count_reg + 1'b1);
                        end
                    end
                    PH_CRC:
                    begin
                        if (byte_count_reg == '0)
                        begin
                            byte_count_next = CNT_W'(1);
                            res.cnt   = 2'd1;
                            res.item0 = sdsh_pkg::mk_tx(sdsh_pkg::BYTE_IDLE, 1'b1);
                        end
                        else
                        begin
                            do_status  = 1'b1;
                            status_val = sdsh_pkg::ST_OK;
                        end
                    end
                    default:
                    begin
                        res.cnt = 2'd0;
                    end
                endcase
            end
            default:
            begin
                res.cnt = 2'd0;
            end
        endcase

        // Start a command: send its first byte once the card shows ready
        if (do_start)
        begin
            cur_cmd_next = start_sel;
            res.cnt      = 2'd1;
            if (rx == sdsh_pkg::BYTE_IDLE)
            begin
                byte_count_next = CNT_W'(1);
                phase_next      = PH_CMD;
                res.item0 = sdsh_pkg::mk_tx(cmd_byte(start_sel, 3'd0, address_hold_reg), 1'b1);
            end
            else
            begin
                phase_next = PH_READY;
                res.item0  = sdsh_pkg::mk_tx(sdsh_pkg::BYTE_IDLE, 1'b1);
            end
        end

        // Report status and drop back to idle
        if (do_status)
        begin
            phase_next = PH_IDLE;
            res.cnt    = 2'd1;
            res.item0  = sdsh_pkg::mk_status(status_val);
        end

        // Mark the final result of the transaction
        if (res.cnt == 2'd1)
        begin
            res.item0.last_out = 1'b1;
        end
        if (res.cnt == 2'd2)
        begin
            res.item1.last_out = 1'b1;
        end
    end

    assign push = res;

    // Hold sequencer state, advance when the transaction is consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            byte_count_reg     <= '0;
            poll_count_reg     <= 4'd0;
            response_bytes_reg <= 40'd0;
            address_hold_reg   <= 32'd0;
            cur_cmd_reg        <= CMD_GO;
        end
        else if (fire)
        begin
            phase_reg          <= phase_next;
            byte_count_reg     <= byte_count_next;
            poll_count_reg     <= poll_count_next;
            response_bytes_reg <= response_bytes_next;
            address_hold_reg   <= address_hold_next;
            cur_cmd_reg        <= cur_cmd_next;
        end
    end

endmodule

### design/sdsh_checker.sv
// ----------------------------------------------------------------------------
// SD SPI host sequencer port checker
// Concurrent checks on the result port, bound to the top level.
// ----------------------------------------------------------------------------
`include "sd_spi_host_sequencer_defines.svh"

module sdsh_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input sdsh_pkg::rsp_t rsp
);

    logic rsp_held;
    logic status_shown;
    logic data_shown;
    logic idle_fill_shown;

    // Classify the result on the port
    assign rsp_held        = rsp_valid && rsp_stall;
    assign status_shown    = rsp_valid && (rsp.out_kind == sdsh_pkg::KIND_STATUS);
    assign data_shown      = rsp_valid && (rsp.out_kind == sdsh_pkg::KIND_DATA);
    assign idle_fill_shown = rsp_valid && (rsp.out_kind == sdsh_pkg::KIND_TX) &&
                             !rsp.select_active;

    // Stalled result stays shown and unchanged
    `SDSH_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_held, rsp_valid && $stable(rsp))

    // Status always closes a transaction
    `SDSH_ASSERT_IMP(a_status_last, clk, rst_n, status_shown, rsp.last_out)

    // Data byte is always followed by its transmit byte
    `SDSH_ASSERT_IMP(a_data_not_last, clk, rst_n, data_shown, !rsp.last_out)

    // Bytes sent with chip select high are idle fill
    `SDSH_ASSERT_IMP(a_deselect_idle, clk, rst_n, idle_fill_shown, rsp.out_byte == 8'hFF)

endmodule

bind sd_spi_host_sequencer sdsh_checker u_sdsh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

### bench/testbench.sv
// ----------------------------------------------------------------------------
// SD SPI host sequencer testbench
// Feeds init requests, block read requests and card bytes through the request
// channel and checks every result against an in-bench prediction of the
// sequencer. Card bytes come from a shadow copy of the sequencer state so that
// most traffic walks through full init and read sequences; the rest is noise,
// aborts and ignored transactions. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          BLOCK_LEN     = sdsh_pkg::BLOCK_BYTES_DEF;
    localparam int          SETTLE_CYCLES = 6;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          PHASE_ITEMS   = 250;
    localparam int          NUM_PHASES    = 6;
    localparam int          MAX_REPORTS   = 10;
    localparam logic [1:0]  REQ_UNUSED    = 2'd3;

    // Sequencer progress through the card protocol
    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_POWER,
        SEQ_FLUSH,
        SEQ_WAIT_READY,
        SEQ_COMMAND,
        SEQ_R1,
        SEQ_TAIL,
        SEQ_TOKEN,
        SEQ_DATA,
        SEQ_CRC
    } seq_phase_t;

    // Card commands, valued by their command index
    typedef enum logic [5:0] {
        CMD_GO   = 6'd0,
        CMD_IFC  = 6'd8,
        CMD_READ = 6'd17,
        CMD_OPC  = 6'd41,
        CMD_APP  = 6'd55,
        CMD_OCR  = 6'd58
    } card_cmd_t;

    typedef struct packed {
        seq_phase_t  phase;
        logic [9:0]  cnt;
        logic [3:0]  polls;
        logic [39:0] resp;
        logic [31:0] addr;
        card_cmd_t   cmd;
        logic [3:0]  retry_lim;
        logic [5:0]  dummy_cnt;
    } seq_state_t;

    typedef struct packed {
        logic [1:0]     cnt;
        sdsh_pkg::rsp_t first;
        sdsh_pkg::rsp_t second;
    } step_out_t;

    logic                            clk;
    logic                            rst_n     = 1'b0;
    logic                            req_valid = 1'b0;
    logic                            req_stall;
    sdsh_pkg::req_t                  req       = '0;
    logic                            rsp_valid;
    logic                            rsp_stall = 1'b0;
    sdsh_pkg::rsp_t                  rsp;
    logic                            cfg_we    = 1'b0;
    logic                            cfg_index = 1'b0;
    logic [sdsh_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    seq_state_t     host_state;
    seq_state_t     plan_state;
    step_out_t      accepted_out;
    sdsh_pkg::req_t card_traffic[$];
    sdsh_pkg::rsp_t bus_results_due[$];
    int             n_queued      = 0;
    int             n_accepted    = 0;
    int             n_counted     = 0;
    int             n_results     = 0;
    int             mismatches    = 0;
    int             send_idle_pct = 0;
    int             stall_pct     = 0;
    int             gap_left      = 0;
    int             stall_left    = 0;
    int unsigned    cycles        = 0;

    sd_spi_host_sequencer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Sequencer prediction
    // ------------------------------------------------------------------
    function automatic seq_state_t power_up_state();
        seq_state_t s;
        s           = '0;
        s.phase     = SEQ_IDLE;
        s.cmd       = CMD_GO;
        s.retry_lim = sdsh_pkg::R1_RETRY_LIMIT_RST;
        s.dummy_cnt = sdsh_pkg::POWER_ON_DUMMY_COUNT_RST;
        return s;
    endfunction

    function automatic void put(inout step_out_t o, input logic [1:0] kind,
                                input logic [7:0] b, input logic sel,
                                input logic [2:0] code);
        sdsh_pkg::rsp_t r;
        r.out_kind      = kind;
        r.out_byte      = b;
        r.select_active = sel;
        r.status_code   = code;
        r.last_out      = 1'b0;
        if (o.cnt == 0)
            o.first = r;
        else
            o.second = r;
        o.cnt = 2'(o.cnt + 1);
    endfunction

    function automatic void send(inout step_out_t o, input logic [7:0] b);
        put(o, sdsh_pkg::KIND_TX, b, 1'b1, sdsh_pkg::ST_OK);
    endfunction

    // Report a status and drop back to idle
    function automatic void finish_with(inout seq_state_t s, inout step_out_t o,
                                        input logic [2:0] code);
        s.phase = SEQ_IDLE;
        put(o, sdsh_pkg::KIND_STATUS, 8'h00, 1'b0, code);
    endfunction

    function automatic logic [7:0] cmd_byte(input seq_state_t s, input int idx);
        logic [7:0]  crc;
        logic [31:0] arg;
        crc = sdsh_pkg::BYTE_IDLE;
        arg = '0;
        case (s.cmd)
            CMD_GO:   crc = 8'h4A;
            CMD_IFC:
            begin
                crc = 8'h43;
                arg = {16'h0000, 8'h01, sdsh_pkg::CHECK_PATTERN};
            end
            CMD_OPC:  arg = 32'h4000_00A0;
            CMD_READ: arg = s.addr;
            default:  ;
        endcase
        if (idx == 0)
            return {2'b01, s.cmd};
        if (idx >= 5)
            return {crc[6:0], 1'b1};
        return arg[8 * (4 - idx) +: 8];
    endfunction

    // Start a command once the card answers idle, else keep polling
    function automatic void begin_cmd(inout seq_state_t s, inout step_out_t o,
                                      input card_cmd_t c, input logic [7:0] rx);
        s.cmd = c;
        if (rx == sdsh_pkg::BYTE_IDLE)
        begin
            s.cnt   = 10'd1;
            s.phase = SEQ_COMMAND;
            send(o, cmd_byte(s, 0));
        end
        else
        begin
            s.phase = SEQ_WAIT_READY;
            send(o, sdsh_pkg::BYTE_IDLE);
        end
    endfunction

    function automatic void r1_taken(inout seq_state_t s, inout step_out_t o,
                                     input logic [7:0] resp);
        case (s.cmd)
            CMD_GO:
                if (resp == sdsh_pkg::R1_IN_IDLE)
                    begin_cmd(s, o, CMD_IFC, resp);
                else
                    finish_with(s, o, sdsh_pkg::ST_RESET_FAIL);
            CMD_APP:
                begin_cmd(s, o, CMD_OPC, resp);
            CMD_OPC:
                begin_cmd(s, o, (resp == sdsh_pkg::R1_IN_IDLE) ? CMD_APP : CMD_OCR, resp);
            CMD_READ:
                if (resp != 8'h00)
                begin
                    finish_with(s, o, sdsh_pkg::ST_READ_REJECT);
                end
                else
                begin
                    s.phase = SEQ_TOKEN;
                    send(o, sdsh_pkg::BYTE_IDLE);
                end
            default:
            begin
                s.resp  = {32'h0, resp};
                s.cnt   = '0;
                s.phase = SEQ_TAIL;
                send(o, sdsh_pkg::BYTE_IDLE);
            end
        endcase
    endfunction

    // Collect the four trailing bytes of an R7 or R3 response
    function automatic void tail_byte(inout seq_state_t s, inout step_out_t o,
                                      input logic [7:0] rx);
        s.resp = {s.resp[31:0], rx};
        s.cnt  = 10'(s.cnt + 1);
        if (s.cnt < 4)
        begin
            send(o, sdsh_pkg::BYTE_IDLE);
        end
        else if (s.cmd == CMD_IFC)
        begin
            if (s.resp[7:0] == sdsh_pkg::CHECK_PATTERN)
                begin_cmd(s, o, CMD_APP, rx);
            else
                finish_with(s, o, sdsh_pkg::ST_VERIFY_FAIL);
        end
        else if (s.resp[39:32] == 8'h00 && s.resp[30])
        begin
            finish_with(s, o, sdsh_pkg::ST_OK);
        end
        else
        begin
            finish_with(s, o, sdsh_pkg::ST_INIT_FAIL);
        end
    endfunction

    function automatic void card_byte(inout seq_state_t s, inout step_out_t o,
                                      input logic [7:0] rx);
        case (s.phase)
            SEQ_POWER:
                if (s.cnt < s.dummy_cnt)
                begin
                    s.cnt = 10'(s.cnt + 1);
                    put(o, sdsh_pkg::KIND_TX, sdsh_pkg::BYTE_IDLE, 1'b0, sdsh_pkg::ST_OK);
                end
                else
                begin
                    s.phase = SEQ_FLUSH;
                    s.cnt   = 10'd1;
                    send(o, sdsh_pkg::BYTE_IDLE);
                end
            SEQ_FLUSH:
                if (s.cnt < 3)
                begin
                    s.cnt = 10'(s.cnt + 1);
                    send(o, sdsh_pkg::BYTE_IDLE);
                end
                else
                begin
                    begin_cmd(s, o, CMD_GO, rx);
                end
            SEQ_WAIT_READY:
                begin_cmd(s, o, s.cmd, rx);
            SEQ_COMMAND:
            begin
                send(o, cmd_byte(s, int'(s.cnt)));
                s.cnt = 10'(s.cnt + 1);
                if (s.cnt >= 6)
                begin
                    s.phase = SEQ_R1;
                    s.polls = 4'd0;
                end
            end
            SEQ_R1:
                if (rx[7] && s.polls < s.retry_lim)
                begin
                    s.polls = 4'(s.polls + 1);
                    send(o, sdsh_pkg::BYTE_IDLE);
                end
                else
                begin
                    r1_taken(s, o, rx);
                end
            SEQ_TAIL:
                tail_byte(s, o, rx);
            SEQ_TOKEN:
            begin
                if (rx == sdsh_pkg::TOKEN_START)
                begin
                    s.phase = SEQ_DATA;
                    s.cnt   = '0;
                end
                send(o, sdsh_pkg::BYTE_IDLE);
            end
            SEQ_DATA:
            begin
                put(o, sdsh_pkg::KIND_DATA, rx, 1'b0, sdsh_pkg::ST_OK);
                if (int'(s.cnt) >= BLOCK_LEN - 1)
                begin
                    s.phase = SEQ_CRC;
                    s.cnt   = '0;
                end
                else
                begin
                    s.cnt = 10'(s.cnt + 1);
                end
                send(o, sdsh_pkg::BYTE_IDLE);
            end
            SEQ_CRC:
                if (s.cnt == 0)
                begin
                    s.cnt = 10'd1;
                    send(o, sdsh_pkg::BYTE_IDLE);
                end
                else
                begin
                    finish_with(s, o, sdsh_pkg::ST_OK);
                end
            default: ;
        endcase
    endfunction

    // Advance the sequencer by one transaction and return its results
    function automatic step_out_t sequencer_step(inout seq_state_t s,
                                                 input sdsh_pkg::req_t it);
        step_out_t o;
        o = '0;
        case (it.req_type)
            sdsh_pkg::REQ_INIT:
                if (!it.card_present)
                begin
                    finish_with(s, o, sdsh_pkg::ST_NO_CARD);
                end
                else
                begin
                    s.phase = SEQ_POWER;
                    s.cnt   = 10'd1;
                    s.polls = 4'd0;
                    s.resp  = '0;
                    put(o, sdsh_pkg::KIND_TX, sdsh_pkg::BYTE_IDLE, 1'b0, sdsh_pkg::ST_OK);
                end
            sdsh_pkg::REQ_READ:
            begin
                s.addr  = it.block_addr;
                s.cmd   = CMD_READ;
                s.polls = 4'd0;
                s.cnt   = '0;
                s.phase = SEQ_WAIT_READY;
                send(o, sdsh_pkg::BYTE_IDLE);
            end
            sdsh_pkg::REQ_RX:
                card_byte(s, o, it.rx_byte);
            default: ;
        endcase
        if (o.cnt == 2)
            o.second.last_out = 1'b1;
        else if (o.cnt == 1)
            o.first.last_out = 1'b1;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Card behavior for stimulus, chosen from the shadow state
    // ------------------------------------------------------------------
    function automatic logic [7:0] card_reply(input seq_state_t s);
        logic [7:0] noise;
        noise = 8'($urandom);
        case (s.phase)
            SEQ_FLUSH, SEQ_WAIT_READY:
                return ($urandom_range(0, 2) != 0) ? sdsh_pkg::BYTE_IDLE : noise;
            SEQ_R1:
            begin
                // busy byte; past the retry limit it becomes the response
                if ($urandom_range(0, 3) == 0)
                    return noise | 8'h80;
                case (s.cmd)
                    CMD_GO:
                        return ($urandom_range(0, 7) != 0) ? sdsh_pkg::R1_IN_IDLE : noise;
                    CMD_IFC:
                        return sdsh_pkg::R1_IN_IDLE;
                    CMD_APP:
                        return {7'd0, noise[0]};
                    CMD_OPC:
                        return ($urandom_range(0, 9) < 6) ? sdsh_pkg::R1_IN_IDLE : 8'h00;
                    CMD_OCR:
                        return ($urandom_range(0, 7) != 0) ? 8'h00 : noise;
                    default:
                        return ($urandom_range(0, 4) != 0) ? 8'h00 : noise;
                endcase
            end
            SEQ_TAIL:
                if (s.cmd == CMD_IFC && s.cnt == 3)
                    return ($urandom_range(0, 7) != 0) ? sdsh_pkg::CHECK_PATTERN : noise;
                else if (s.cmd == CMD_OCR && s.cnt == 0)
                    return ($urandom_range(0, 7) != 0) ? (noise | 8'h40) : noise;
                else
                    return noise;
            SEQ_TOKEN:
                return ($urandom_range(0, 2) == 0) ? sdsh_pkg::TOKEN_START : sdsh_pkg::BYTE_IDLE;
            default:
                return noise;
        endcase
    endfunction

    function automatic sdsh_pkg::req_t item_of(input logic [1:0] kind,
                                               input logic [31:0] addr,
                                               input logic [7:0] rx,
                                               input logic present);
        sdsh_pkg::req_t it;
        it.req_type     = kind;
        it.block_addr   = addr;
        it.rx_byte      = rx;
        it.card_present = present;
        return it;
    endfunction

    function automatic sdsh_pkg::req_t pick_item(input seq_state_t s);
        sdsh_pkg::req_t it;
        int             roll;
        it   = item_of(sdsh_pkg::REQ_RX, $urandom, 8'($urandom), 1'($urandom_range(0, 1)));
        roll = $urandom_range(0, 999);
        if (s.phase == SEQ_IDLE)
        begin
            if (roll < 30)
            begin
                it.req_type = sdsh_pkg::REQ_RX;
            end
            else if (roll < 50)
            begin
                it.req_type = REQ_UNUSED;
            end
            else if (roll < 750)
            begin
                it.req_type     = sdsh_pkg::REQ_INIT;
                it.card_present = (roll >= 110);
            end
            else
            begin
                it.req_type = sdsh_pkg::REQ_READ;
            end
            return it;
        end
        // abort a running sequence now and then, but let block data finish
        if (roll < 6 && s.phase != SEQ_DATA)
        begin
            it.req_type     = (roll < 3) ? sdsh_pkg::REQ_INIT : sdsh_pkg::REQ_READ;
            it.card_present = 1'b1;
            return it;
        end
        if (roll < 12)
            it.req_type = REQ_UNUSED;
        else if (roll >= 40)
            it.rx_byte = card_reply(s);
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus queue
    // ------------------------------------------------------------------
    task automatic add(input sdsh_pkg::req_t it);
        step_out_t unused_out;
        if (it.req_type != REQ_UNUSED &&
            !(it.req_type == sdsh_pkg::REQ_RX && plan_state.phase == SEQ_IDLE))
            n_counted++;
        unused_out = sequencer_step(plan_state, it);
        card_traffic.push_back(it);
        n_queued++;
    endtask

    task automatic fill(input int n);
        int goal;
        goal = n_counted + n;
        while (n_counted < goal)
            add(pick_item(plan_state));
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (n_accepted != n_queued || bus_results_due.size() != 0);
    endtask

    task automatic write_reg(input logic idx, input logic [sdsh_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == sdsh_pkg::CFG_R1_RETRY_LIMIT)
        begin
            host_state.retry_lim = val[3:0];
            plan_state.retry_lim = val[3:0];
        end
        else
        begin
            host_state.dummy_cnt = val;
            plan_state.dummy_cnt = val;
        end
    endtask

    task automatic directed_items();
        // ignored transactions
        add(item_of(sdsh_pkg::REQ_RX, 32'h0, 8'h00, 1'b0));
        add(item_of(REQ_UNUSED, 32'hFFFF_FFFF, 8'hFF, 1'b1));
        // no card, then a read without init at the top address
        add(item_of(sdsh_pkg::REQ_INIT, 32'h0, 8'h00, 1'b0));
        add(item_of(sdsh_pkg::REQ_READ, 32'hFFFF_FFFF, 8'h00, 1'b0));
        add(item_of(sdsh_pkg::REQ_RX, 32'h0, 8'h00, 1'b0));
        add(item_of(sdsh_pkg::REQ_RX, 32'h0, 8'hFF, 1'b0));
        add(item_of(sdsh_pkg::REQ_RX, 32'h0, 8'h00, 1'b0));
        add(item_of(sdsh_pkg::REQ_RX, 32'h0, 8'hFF, 1'b0));
        add(item_of(sdsh_pkg::REQ_RX, 32'h0, 8'h5A, 1'b0));
        add(item_of(sdsh_pkg::REQ_RX, 32'h0, 8'hA5, 1'b0));
        add(item_of(sdsh_pkg::REQ_RX, 32'h0, 8'h00, 1'b0));
        // busy polls, then a nonzero R1 rejects the read
        add(item_of(sdsh_pkg::REQ_RX, 32'h0, 8'hFF, 1'b0));
        add(item_of(sdsh_pkg::REQ_RX, 32'h0, 8'h80, 1'b0));
        add(item_of(sdsh_pkg::REQ_RX, 32'h0, 8'h04, 1'b0));
        // read at address zero, aborted by an init mid command
        add(item_of(sdsh_pkg::REQ_READ, 32'h0, 8'hFF, 1'b1));
        add(item_of(sdsh_pkg::REQ_RX, 32'h0, 8'hFF, 1'b0));
        add(item_of(sdsh_pkg::REQ_RX, 32'h0, 8'h12, 1'b0));
        add(item_of(sdsh_pkg::REQ_INIT, 32'h0, 8'h00, 1'b1));
        add(item_of(sdsh_pkg::REQ_RX, 32'h0, 8'h00, 1'b0));
    endtask

    // ------------------------------------------------------------------
    // Request driver: accept, predict, then present the next transaction
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            gap_left   = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                accepted_out = sequencer_step(host_state, req);
                if (accepted_out.cnt > 0)
                    bus_results_due.push_back(accepted_out.first);
                if (accepted_out.cnt > 1)
                    bus_results_due.push_back(accepted_out.second);
                n_accepted++;
            end
            if (!req_valid || !req_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (card_traffic.size() > 0)
                begin
                    req       <= card_traffic.pop_front();
                    req_valid <= 1'b1;
                    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
                        gap_left = $urandom_range(1, 16);
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and stall generator
    // ------------------------------------------------------------------
    task automatic check_result(input sdsh_pkg::rsp_t got);
        sdsh_pkg::rsp_t want;
        n_results++;
        if (bus_results_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("result %0d unexpected: kind %0d byte %02h ",
                         n_results, got.out_kind, got.out_byte,
                         "sel %0b status %0d last %0b",
                         got.select_active, got.status_code, got.last_out);
        end
        else
        begin
            want = bus_results_due.pop_front();
            if (got.out_kind !== want.out_kind || got.out_byte !== want.out_byte ||
                got.select_active !== want.select_active ||
                got.status_code !== want.status_code || got.last_out !== want.last_out)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d mismatch: expected kind %0d byte %02h sel %0b ",
                             n_results, want.out_kind, want.out_byte, want.select_active,
                             "status %0d last %0b, got kind %0d byte %02h ",
                             want.status_code, want.last_out, got.out_kind, got.out_byte,
                             "sel %0b status %0d last %0b",
                             got.select_active, got.status_code, got.last_out);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
                check_result(rsp);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(0, 15);
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // Hold a hard ceiling on run length
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Run control: phases of register settings and traffic
    // ------------------------------------------------------------------
    initial
    begin
        logic [3:0]                      retry_set [NUM_PHASES];
        logic [sdsh_pkg::CFG_DATA_W-1:0] dummy_set [NUM_PHASES];
        int                              idle_set  [NUM_PHASES];
        int                              stall_set [NUM_PHASES];

        retry_set = '{sdsh_pkg::R1_RETRY_LIMIT_RST, 4'd0, 4'd15, 4'd1,
                      4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))};
        dummy_set = '{sdsh_pkg::POWER_ON_DUMMY_COUNT_RST, 6'd0, 6'd63, 6'd1,
                      6'($urandom_range(1, 63)), 6'($urandom_range(0, 63))};
        idle_set  = '{20, 0, 40, 15, 30, 0};
        stall_set = '{20, 40, 0, 15, 30, 0};
        host_state = power_up_state();
        plan_state = power_up_state();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // reconfigure only with nothing in flight
            if (p > 0)
            begin
                wait_drained();
                repeat (SETTLE_CYCLES) @(posedge clk);
                write_reg(sdsh_pkg::CFG_R1_RETRY_LIMIT, {2'b00, retry_set[p]});
                write_reg(sdsh_pkg::CFG_POWER_ON_DUMMY_COUNT, dummy_set[p]);
            end
            send_idle_pct = idle_set[p];
            stall_pct     = stall_set[p];
            if (p == 0)
                directed_items();
            if (p == 2)
            begin
                // stop sending mid sequence until every result is back
                fill(PHASE_ITEMS / 2);
                wait_drained();
                fill(PHASE_ITEMS / 2);
            end
            else
            begin
                fill(PHASE_ITEMS);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && bus_results_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
